/* rtl/core/iie_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package iie_pkg;

  // Register file geometry
  localparam int unsigned NumRegs = 32;
  localparam int unsigned RegAw   = 5;

  // Operation codes; codes 24 to 31 are no-ops
  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_SUB   = 5'd1,
    OP_AND   = 5'd2,
    OP_OR    = 5'd3,
    OP_XOR   = 5'd4,
    OP_SLL   = 5'd5,
    OP_SRL   = 5'd6,
    OP_SLT   = 5'd7,
    OP_ADDI  = 5'd8,
    OP_ANDI  = 5'd9,
    OP_ORI   = 5'd10,
    OP_XORI  = 5'd11,
    OP_SLLI  = 5'd12,
    OP_SRLI  = 5'd13,
    OP_SLTI  = 5'd14,
    OP_JALR  = 5'd15,
    OP_LW    = 5'd16,
    OP_SW    = 5'd17,
    OP_BNE   = 5'd18,
    OP_BEQ   = 5'd19,
    OP_BGE   = 5'd20,
    OP_BLT   = 5'd21,
    OP_AUIPC = 5'd22,
    OP_JAL   = 5'd23
  } op_e;

  // Execute stage result handed to the write-back stage
  typedef struct packed {
    logic [31:0] val;      // register write value, 0 when nothing is written
    logic        wr;       // register write (rd nonzero)
    logic        load;     // in-range load, data comes from memory
    logic        store;    // in-range store
    logic        fault;    // out-of-range load or store
    logic [31:0] addr;     // src1 + immediate
    logic [15:0] next_pc;
    logic        redir;
  } ex_res_t;

endpackage

`default_nettype wire

/* rtl/core/iie_regfile.sv */
`timescale 1ns / 1ps
`default_nettype none

// 32 x 32 register file, two synchronous read ports, one write port.
// Unwritten entries read as zero. A write on the read edge is bypassed,
// and a later write to a held read address patches the held read data.
module iie_regfile (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          re_i,
  input  wire logic [iie_pkg::RegAw-1:0]     ra_addr_i,
  input  wire logic [iie_pkg::RegAw-1:0]     rb_addr_i,
  output logic      [31:0]                   ra_data_o,
  output logic      [31:0]                   rb_data_o,
  input  wire logic                          we_i,
  input  wire logic [iie_pkg::RegAw-1:0]     waddr_i,
  input  wire logic [31:0]                   wdata_i
);

  logic [31:0]                   mem_q [iie_pkg::NumRegs];
  logic [iie_pkg::NumRegs-1:0]   vld_q;
  logic [iie_pkg::RegAw-1:0]     ra_q, rb_q;
  logic [31:0]                   ra_data_q, rb_data_q;

  // Entry valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // Storage write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports with write bypass and hold-time patching
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      ra_q <= ra_addr_i;
      rb_q <= rb_addr_i;
      if (we_i && waddr_i == ra_addr_i) begin
        ra_data_q <= wdata_i;
      end else begin
        ra_data_q <= vld_q[ra_addr_i] ? mem_q[ra_addr_i] : 32'd0;
      end
      if (we_i && waddr_i == rb_addr_i) begin
        rb_data_q <= wdata_i;
      end else begin
        rb_data_q <= vld_q[rb_addr_i] ? mem_q[rb_addr_i] : 32'd0;
      end
    end else begin
      if (we_i && waddr_i == ra_q) begin
        ra_data_q <= wdata_i;
      end
      if (we_i && waddr_i == rb_q) begin
        rb_data_q <= wdata_i;
      end
    end
  end

  assign ra_data_o = ra_data_q;
  assign rb_data_o = rb_data_q;

endmodule

`default_nettype wire

/* rtl/core/iie_dmem.sv */
`timescale 1ns / 1ps
`default_nettype none

// Byte data memory as four byte banks, so an unaligned word is one access.
// Byte address A lives in bank A[1:0], row A >> 2. After reset a clear
// pass zeroes one row of every bank per cycle while busy_o is high.
module iie_dmem #(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  output logic                               busy_o,
  input  wire logic                          rd_en_i,
  input  wire logic                          wr_en_i,
  input  wire logic [$clog2(MEM_BYTES)-1:0]  addr_i,
  input  wire logic [31:0]                   wdata_i,
  output logic      [31:0]                   rdata_o
);

  localparam int unsigned Aw   = $clog2(MEM_BYTES);
  localparam int unsigned Rw   = Aw - 2;
  localparam int unsigned Rows = (MEM_BYTES + 3) / 4;

  logic            busy_q;
  logic [Rw-1:0]   clr_row_q;
  logic [1:0]      off, off_q;
  logic [Rw-1:0]   row0;
  logic [3:0][7:0] rdbank;

  assign off  = addr_i[1:0];
  assign row0 = addr_i[Aw-1:2];

  // Clear pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_row_q <= '0;
    end else if (busy_q) begin
      if (clr_row_q == Rw'(Rows - 1)) begin
        busy_q <= 1'b0;
      end
      clr_row_q <= clr_row_q + 1'b1;
    end
  end

  assign busy_o = busy_q;

  // Byte offset of the read word, needed to rotate the bank data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      off_q <= off;
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]    mem_q [Rows];
    logic [7:0]    rbyte_q;
    logic [1:0]    idx;
    logic [Rw-1:0] row;
    logic [7:0]    wbyte;

    // Bank b holds byte (b - off) of the word; it wraps to the next row
    assign idx   = 2'(b) - off;
    assign row   = row0 + Rw'(2'(b) < off);
    assign wbyte = wdata_i[8*idx +: 8];

    always_ff @(posedge clk_i) begin
      if (busy_q) begin
        mem_q[clr_row_q] <= '0;
      end else if (wr_en_i) begin
        mem_q[row] <= wbyte;
      end
      if (rd_en_i) begin
        rbyte_q <= mem_q[row];
      end
    end

    assign rdbank[b] = rbyte_q;
  end

  // Little-endian word assembly
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata_o[8*i +: 8] = rdbank[2'(off_q + 2'(i))];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/iie_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

// Execute logic: ALU, compares, branch and jump targets, memory address
module iie_alu #(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  wire iie_pkg::op_e                  op_i,
  input  wire logic [iie_pkg::RegAw-1:0]     rd_i,
  input  wire logic [31:0]                   imm_i,
  input  wire logic [31:0]                   a_i,
  input  wire logic [31:0]                   b_i,
  input  wire logic [15:0]                   pc_i,
  input  wire logic [15:0]                   target_i,
  output iie_pkg::ex_res_t                   res_o
);

  localparam logic [31:0] AddrMax = 32'(MEM_BYTES - 4);

  logic [31:0] sum_ai;
  logic [31:0] link;
  logic [15:0] seq;
  logic        mem_ok;
  logic        lt_ab, lt_ai;
  logic [31:0] val;
  logic        wr;
  logic        load, store, fault;
  logic [15:0] next;

  assign sum_ai = a_i + imm_i;
  assign seq    = pc_i + 16'd1;
  assign link   = {16'd0, pc_i} + 32'd1;
  assign mem_ok = sum_ai <= AddrMax;
  assign lt_ab  = $signed(a_i) < $signed(b_i);
  assign lt_ai  = $signed(a_i) < $signed(imm_i);

  always_comb begin
    val   = '0;
    wr    = 1'b0;
    load  = 1'b0;
    store = 1'b0;
    fault = 1'b0;
    next  = seq;
    case (op_i)
      iie_pkg::OP_ADD:   begin val = a_i + b_i;          wr = 1'b1; end
      iie_pkg::OP_SUB:   begin val = a_i - b_i;          wr = 1'b1; end
      iie_pkg::OP_AND:   begin val = a_i & b_i;          wr = 1'b1; end
      iie_pkg::OP_OR:    begin val = a_i | b_i;          wr = 1'b1; end
      iie_pkg::OP_XOR:   begin val = a_i ^ b_i;          wr = 1'b1; end
      iie_pkg::OP_SLL:   begin val = a_i << b_i[4:0];    wr = 1'b1; end
      iie_pkg::OP_SRL:   begin val = a_i >> b_i[4:0];    wr = 1'b1; end
      iie_pkg::OP_SLT:   begin val = {31'd0, lt_ab};     wr = 1'b1; end
      iie_pkg::OP_ADDI:  begin val = sum_ai;             wr = 1'b1; end
      iie_pkg::OP_ANDI:  begin val = a_i & imm_i;        wr = 1'b1; end
      iie_pkg::OP_ORI:   begin val = a_i | imm_i;        wr = 1'b1; end
      iie_pkg::OP_XORI:  begin val = a_i ^ imm_i;        wr = 1'b1; end
      iie_pkg::OP_SLLI:  begin val = a_i << imm_i[4:0];  wr = 1'b1; end
      iie_pkg::OP_SRLI:  begin val = a_i >> imm_i[4:0];  wr = 1'b1; end
      iie_pkg::OP_SLTI:  begin val = {31'd0, lt_ai};     wr = 1'b1; end
      iie_pkg::OP_JALR: begin
        val  = link;
        wr   = 1'b1;
        next = sum_ai[15:0];
      end
      iie_pkg::OP_LW: begin
        load  = mem_ok;
        wr    = mem_ok;
        fault = !mem_ok;
      end
      iie_pkg::OP_SW: begin
        store = mem_ok;
        fault = !mem_ok;
      end
      iie_pkg::OP_BNE:   if (a_i != b_i) next = target_i;
      iie_pkg::OP_BEQ:   if (a_i == b_i) next = target_i;
      iie_pkg::OP_BGE:   if (!lt_ab) next = target_i;
      iie_pkg::OP_BLT:   if (lt_ab) next = target_i;
      iie_pkg::OP_AUIPC: begin val = imm_i; wr = 1'b1; end
      iie_pkg::OP_JAL: begin
        val  = link;
        wr   = 1'b1;
        next = imm_i[15:0];
      end
      default: ;
    endcase
  end

  // Register zero is never written
  always_comb begin
    res_o.wr      = wr && (rd_i != '0);
    res_o.val     = res_o.wr ? val : 32'd0;
    res_o.load    = load;
    res_o.store   = store;
    res_o.fault   = fault;
    res_o.addr    = sum_ai;
    res_o.next_pc = next;
    res_o.redir   = next != seq;
  end

endmodule

`default_nettype wire

/* rtl/core/integer_instruction_executor.sv */
`timescale 1ns / 1ps
`default_nettype none

// Integer instruction executor.
// Input channel: one decoded instruction per request (in_valid_i/in_stall_o).
// Output channel: one result per instruction, in order (out_valid_o/out_stall_i).
// Pipeline: accept -> register file read -> execute (ALU, address, store
// write, load read issue) -> write-back into an output register.
// Results pass the execute and write-back stages, then the output register.
// Throughput: one instruction per cycle while in_stall_o is low. A load whose
// destination is a source of the very next instruction stalls it, since the load
// data only leaves the data memory read register in the write-back stage.
// Register file: 32 x 32, two read ports and one write port, zero after reset.
// Data memory: MEM_BYTES bytes in four byte banks, one word access per cycle.
// Reset: after rst_ni rises, a clear pass zeroes the data memory one row of
// four bytes per cycle, (MEM_BYTES + 3) / 4 rows (1024 at the default);
// in_stall_o stays high until the pass ends.
// Receiver stall: the output register holds its result; the pipeline behind it
// fills up and then in_stall_o rises. A new request is still taken while a
// finished result waits, as long as a pipeline stage is free.
module integer_instruction_executor #(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [4:0]  operation_i,
  input  wire logic [4:0]  dest_reg_i,
  input  wire logic [4:0]  src1_reg_i,
  input  wire logic [4:0]  src2_reg_i,
  input  wire logic [31:0] immediate_i,
  input  wire logic [15:0] current_pc_i,
  input  wire logic [15:0] branch_target_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      out_next_pc_o,
  output logic             out_redirected_o,
  output logic [31:0]      out_write_value_o,
  output logic             out_memory_fault_o
);

  localparam int unsigned Aw = $clog2(MEM_BYTES);

  // Execute stage
  logic                          s1_v_q;
  iie_pkg::op_e                  s1_op_q;
  logic [iie_pkg::RegAw-1:0]     s1_rd_q, s1_rs1_q, s1_rb_q;
  logic [31:0]                   s1_imm_q;
  logic [15:0]                   s1_pc_q, s1_tgt_q;

  // Write-back stage
  logic                          s2_v_q;
  logic [31:0]                   s2_val_q;
  logic                          s2_wr_q, s2_load_q, s2_fault_q, s2_redir_q;
  logic [iie_pkg::RegAw-1:0]     s2_rd_q;
  logic [15:0]                   s2_next_q;

  // Output register
  logic                          out_v_q;
  logic [15:0]                   out_next_q;
  logic                          out_redir_q, out_fault_q;
  logic [31:0]                   out_val_q;

  logic                          accept, adv1, adv2, s2_free, hazard;
  logic                          clearing;
  logic [iie_pkg::RegAw-1:0]     rb_sel;
  logic [31:0]                   ra_data, rb_data, op_a, op_b;
  logic [31:0]                   ld_word, wb_val;
  logic                          rf_we;
  iie_pkg::ex_res_t              ex_res;

  // Pipeline control
  assign adv2    = s2_v_q && (!out_v_q || !out_stall_i);
  assign s2_free = !s2_v_q || adv2;
  assign hazard  = s1_v_q && s2_v_q && s2_load_q && s2_wr_q &&
                   (s2_rd_q == s1_rs1_q || s2_rd_q == s1_rb_q);
  assign adv1    = s1_v_q && s2_free && !hazard;
  assign in_stall_o = clearing || (s1_v_q && !adv1);
  assign accept  = in_valid_i && !in_stall_o;

  // A store reads its data register on the second port
  assign rb_sel = (iie_pkg::op_e'(operation_i) == iie_pkg::OP_SW) ? dest_reg_i : src2_reg_i;

  iie_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (accept),
    .ra_addr_i (src1_reg_i),
    .rb_addr_i (rb_sel),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data),
    .we_i      (rf_we),
    .waddr_i   (s2_rd_q),
    .wdata_i   (wb_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (adv1) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= iie_pkg::op_e'(operation_i);
      s1_rd_q  <= dest_reg_i;
      s1_rs1_q <= src1_reg_i;
      s1_rb_q  <= rb_sel;
      s1_imm_q <= immediate_i;
      s1_pc_q  <= current_pc_i;
      s1_tgt_q <= branch_target_i;
    end
  end

  // Forward a pending ALU write from write-back; loads interlock instead
  always_comb begin
    op_a = ra_data;
    op_b = rb_data;
    if (s2_v_q && s2_wr_q && !s2_load_q) begin
      if (s2_rd_q == s1_rs1_q) op_a = s2_val_q;
      if (s2_rd_q == s1_rb_q)  op_b = s2_val_q;
    end
  end

  iie_alu #(
    .MEM_BYTES (MEM_BYTES)
  ) u_alu (
    .op_i     (s1_op_q),
    .rd_i     (s1_rd_q),
    .imm_i    (s1_imm_q),
    .a_i      (op_a),
    .b_i      (op_b),
    .pc_i     (s1_pc_q),
    .target_i (s1_tgt_q),
    .res_o    (ex_res)
  );

  iie_dmem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .busy_o  (clearing),
    .rd_en_i (adv1 && ex_res.load),
    .wr_en_i (adv1 && ex_res.store),
    .addr_i  (ex_res.addr[Aw-1:0]),
    .wdata_i (op_b),
    .rdata_o (ld_word)
  );

  // Write-back stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv1) begin
      s2_v_q <= 1'b1;
    end else if (adv2) begin
      s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s2_val_q   <= ex_res.val;
      s2_wr_q    <= ex_res.wr;
      s2_load_q  <= ex_res.load;
      s2_fault_q <= ex_res.fault;
      s2_redir_q <= ex_res.redir;
      s2_next_q  <= ex_res.next_pc;
      s2_rd_q    <= s1_rd_q;
    end
  end

  assign wb_val = (s2_load_q && s2_wr_q) ? ld_word : s2_val_q;
  assign rf_we  = adv2 && s2_wr_q;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv2) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      out_next_q  <= s2_next_q;
      out_redir_q <= s2_redir_q;
      out_fault_q <= s2_fault_q;
      out_val_q   <= wb_val;
    end
  end

  assign out_valid_o        = out_v_q;
  assign out_next_pc_o      = out_next_q;
  assign out_redirected_o   = out_redir_q;
  assign out_write_value_o  = out_val_q;
  assign out_memory_fault_o = out_fault_q;

  // Checks
  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> s2_rd_q != '0)
    else $error("register zero written");

  a_no_mem_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !(s1_v_q || s2_v_q))
    else $error("instruction in flight during memory clear");

  a_fault_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_fault_q |-> out_val_q == 32'd0 && !out_redir_q)
    else $error("faulting access wrote a register or redirected");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_v_q)
    else $error("accepted request lost");

endmodule

`default_nettype wire
